// ===== hw/rtl/sliding_window_category_histogram_assert.svh =====
`ifndef SLIDING_WINDOW_CATEGORY_HISTOGRAM_ASSERT_SVH
`define SLIDING_WINDOW_CATEGORY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWCH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("swch: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SWCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("swch: next-cycle check failed");

`endif

// ===== hw/rtl/swch_pkg.sv =====
package swch_pkg;

    localparam int WINDOW_DEPTH_DEF   = 256;
    localparam int NUM_CATEGORIES_DEF = 16;

    localparam int CAT_W       = 4;
    localparam int BIN_CNT_W   = 9;
    localparam int BIN_CNT_MAX = 511;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_DEC,
        ST_NEW_RD,
        ST_INC,
        ST_BIN_RD,
        ST_BIN_OUT
    } swch_state_t;

endpackage

// ===== hw/rtl/sliding_window_category_histogram.sv =====
// Sample word: accepted in ST_IDLE, then the count update steps through ST_OLD_RD,
// ST_DEC, ST_NEW_RD and ST_INC, using one shared +/-1 unit and a single-port
// count memory; s_ready returns when the update is done. Read word: per category,
// a count memory read (ST_BIN_RD), then the result word held until taken (ST_BIN_OUT).
// Reset clears the write position, the wrap flag and the count valid bits at
// once; no clearing pass runs and the block is ready as soon as reset is released.
module sliding_window_category_histogram
    import swch_pkg::*;
#(
    parameter int WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
    parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [CAT_W-1:0]     s_category,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CAT_W-1:0]     m_bin_index,
    output logic [BIN_CNT_W-1:0] m_bin_count,
    output logic                 m_last_bin
);

    `include "sliding_window_category_histogram_assert.svh"

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int AW    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_DEPTH - 1);
    localparam logic [AW-1:0] BIN_LAST = AW'(NUM_CATEGORIES - 1);

    swch_state_t state_reg, state_next;

    logic [PW-1:0]    wr_pos_reg, wr_pos_next;
    logic             wrapped_reg, wrapped_next;
    logic [CAT_W-1:0] new_cat_reg, new_cat_next;
    logic [CAT_W-1:0] old_cat_reg, old_cat_next;
    logic [AW-1:0]    bin_reg, bin_next;

    logic [CAT_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [CAT_W-1:0] ring_rd_reg;
    logic             ring_we;

    logic             cnt_rd_en;
    logic             cnt_wr_en;
    logic [AW-1:0]    cnt_addr;
    logic [CNT_W-1:0] cnt_wdata;
    logic [CNT_W-1:0] cnt_rdata;
    logic [CNT_W-1:0] cnt_delta;
    logic             step_up;
    logic [31:0]      cnt_wide;
    logic [31:0]      bin_wide;
    logic [CAT_W-1:0] cat_mapped;

    // Codes outside the category range are recorded as the empty category.
    assign cat_mapped = (32'(s_category) < 32'(NUM_CATEGORIES)) ? s_category : '0;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[wr_pos_reg] <= new_cat_reg;
        end
        ring_rd_reg <= ring_mem[wr_pos_reg];
    end

    // Shared unit: one +1/-1 step on the count just read; a zero never
    // goes below zero.
    assign step_up   = (state_reg == ST_INC);
    assign cnt_delta = step_up ? CNT_W'(1) :
                       ((cnt_rdata != '0) ? '1 : '0);
    assign cnt_wdata = cnt_rdata + cnt_delta;

    swch_cnt_ram #(
        .WINDOW_DEPTH   (WINDOW_DEPTH),
        .NUM_CATEGORIES (NUM_CATEGORIES)
    ) u_cnt_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (cnt_rd_en),
        .wr_en   (cnt_wr_en),
        .addr    (cnt_addr),
        .wdata   (cnt_wdata),
        .rdata   (cnt_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_pos_reg  <= '0;
            wrapped_reg <= 1'b0;
            bin_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            wr_pos_reg  <= wr_pos_next;
            wrapped_reg <= wrapped_next;
            bin_reg     <= bin_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_cat_reg <= new_cat_next;
        old_cat_reg <= old_cat_next;
    end

    always_comb begin
        state_next   = state_reg;
        wr_pos_next  = wr_pos_reg;
        wrapped_next = wrapped_reg;
        bin_next     = bin_reg;
        new_cat_next = new_cat_reg;
        old_cat_next = old_cat_reg;
        ring_we      = 1'b0;
        cnt_rd_en    = 1'b0;
        cnt_wr_en    = 1'b0;
        cnt_addr     = bin_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    new_cat_next = cat_mapped;
                    bin_next     = '0;
                    state_next   = (s_req_type == REQ_READ) ? ST_BIN_RD : ST_OLD_RD;
                end
            end
            ST_OLD_RD: begin
                // Until the ring has wrapped once, the slot still holds its
                // reset value.
                old_cat_next = wrapped_reg ? ring_rd_reg : '0;
                cnt_rd_en    = 1'b1;
                cnt_addr     = AW'(32'(old_cat_next));
                ring_we      = 1'b1;
                if (wr_pos_reg == POS_LAST) begin
                    wr_pos_next  = '0;
                    wrapped_next = 1'b1;
                end else begin
                    wr_pos_next = wr_pos_reg + PW'(1);
                end
                state_next = ST_DEC;
            end
            ST_DEC: begin
                cnt_wr_en  = 1'b1;
                cnt_addr   = AW'(32'(old_cat_reg));
                state_next = ST_NEW_RD;
            end
            ST_NEW_RD: begin
                cnt_rd_en  = 1'b1;
                cnt_addr   = AW'(32'(new_cat_reg));
                state_next = ST_INC;
            end
            ST_INC: begin
                cnt_wr_en  = 1'b1;
                cnt_addr   = AW'(32'(new_cat_reg));
                state_next = ST_IDLE;
            end
            ST_BIN_RD: begin
                cnt_rd_en  = 1'b1;
                state_next = ST_BIN_OUT;
            end
            ST_BIN_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (bin_reg == BIN_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        bin_next   = bin_reg + AW'(1);
                        state_next = ST_BIN_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result word is held in the count read register while it waits.
    assign cnt_wide    = 32'(cnt_rdata);
    assign bin_wide    = 32'(bin_reg);
    assign m_bin_count = (cnt_wide > 32'(BIN_CNT_MAX)) ? BIN_CNT_W'(BIN_CNT_MAX)
                                                       : BIN_CNT_W'(cnt_wide);
    assign m_bin_index = CAT_W'(bin_wide);
    assign m_last_bin  = (bin_reg == BIN_LAST);

    `SWCH_ASSERT_NOW(a_one_side_open, s_ready, !m_valid)
    `SWCH_ASSERT_NEXT(a_last_frees_input, m_valid && m_ready && m_last_bin, s_ready)
    `SWCH_ASSERT_NEXT(a_read_starts_at_zero, s_valid && s_ready && (s_req_type == REQ_READ),
                      (state_reg == ST_BIN_RD) && (bin_reg == '0))
    `SWCH_ASSERT_NEXT(a_pos_steps_once, state_reg == ST_OLD_RD,
                      (wr_pos_reg == (($past(wr_pos_reg) == POS_LAST) ? '0 :
                                      $past(wr_pos_reg) + PW'(1))))

endmodule

// ===== hw/rtl/swch_cnt_ram.sv =====
module swch_cnt_ram
    import swch_pkg::*;
#(
    parameter int WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
    parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1),
    localparam int AW    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [CNT_W-1:0] wdata,
    output logic [CNT_W-1:0] rdata
);

    logic [CNT_W-1:0]          cnt_mem [NUM_CATEGORIES];
    logic [CNT_W-1:0]          mem_q_reg;
    logic                      hit_valid_reg;
    logic                      hit_zero_reg;
    logic [NUM_CATEGORIES-1:0] valid_reg;
    logic [NUM_CATEGORIES-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[addr] <= wdata;
        end
        if (rd_en) begin
            mem_q_reg <= cnt_mem[addr];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[addr] = 1'b1;
        end
    end

    // An entry never written reads as its reset value: the whole window for
    // category zero and nothing for every other category.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
            hit_zero_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                hit_valid_reg <= valid_reg[addr];
                hit_zero_reg  <= (addr == '0);
            end
        end
    end

    assign rdata = hit_valid_reg ? mem_q_reg :
                   (hit_zero_reg ? CNT_W'(WINDOW_DEPTH) : '0);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import swch_pkg::*;

    localparam int DEPTH      = WINDOW_DEPTH_DEF;
    localparam int NCAT       = NUM_CATEGORIES_DEF;
    localparam int RAND_WORDS = 430;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic             req;
        logic [CAT_W-1:0] cat;
    } hist_word_t;

    typedef struct packed {
        logic [CAT_W-1:0]     idx;
        logic [BIN_CNT_W-1:0] cnt;
        logic                 last;
    } bin_report_t;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_SAMPLE;
    logic [CAT_W-1:0]     s_category = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic [CAT_W-1:0]     m_bin_index;
    logic [BIN_CNT_W-1:0] m_bin_count;
    logic                 m_last_bin;

    hist_word_t  pending_words[$];
    bin_report_t expected_bins[$];
    hist_word_t  cur_word;

    // Own copy of the window, its write position and the per-category tallies.
    logic [CAT_W-1:0] win_slots[DEPTH];
    int unsigned      win_wr_pos;
    int unsigned      cat_tally[NCAT];

    int unsigned words_total    = 0;
    int unsigned words_accepted = 0;
    int unsigned err_count      = 0;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned idle_cycles    = 0;
    logic [31:0] stall_pat      = '1;
    int unsigned stall_ph       = 0;

    sliding_window_category_histogram DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_category  (s_category),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_bin_count (m_bin_count),
        .m_last_bin  (m_last_bin)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++) win_slots[i] = '0;
        for (int k = 0; k < NCAT; k++) cat_tally[k] = 0;
        cat_tally[0] = DEPTH;
        win_wr_pos = 0;
    endfunction

    // Updates the window for a sample word, or queues one report per category
    // for a read word.
    function automatic void apply_word(hist_word_t w);
        int unsigned c;
        int unsigned old;
        bin_report_t rep;
        if (w.req == REQ_READ) begin
            for (int k = 0; k < NCAT; k++) begin
                rep.idx  = CAT_W'(k);
                rep.cnt  = (cat_tally[k] > BIN_CNT_MAX) ? BIN_CNT_W'(BIN_CNT_MAX)
                                                        : BIN_CNT_W'(cat_tally[k]);
                rep.last = (k == NCAT - 1);
                expected_bins.push_back(rep);
            end
        end else begin
            c = 32'(w.cat);
            if (c >= NCAT) c = 0;
            old = 32'(win_slots[win_wr_pos]);
            if (old < NCAT && cat_tally[old] > 0) cat_tally[old]--;
            cat_tally[c]++;
            win_slots[win_wr_pos] = CAT_W'(c);
            win_wr_pos = (win_wr_pos + 1) % DEPTH;
        end
    endfunction

    function automatic void push_word(logic req, int unsigned cat);
        hist_word_t w;
        w.req = req;
        w.cat = CAT_W'(cat);
        pending_words.push_back(w);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_window();
        end else begin
            if (s_valid && s_ready) begin
                apply_word(cur_word);
                words_accepted++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_words.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid    <= 1'b0;
                    s_req_type <= 1'($urandom_range(0, 1));
                    s_category <= CAT_W'($urandom);
                end else begin
                    cur_word = pending_words.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= cur_word.req;
                    s_category <= cur_word.cat;
                end
            end
        end
    end

    // Receiver: ready follows a 32-bit pattern that is redrawn on each wrap.
    always @(posedge aclk) begin
        bin_report_t exp_bin;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected word idx=%0d count=%0d last=%0b",
                                 m_bin_index, m_bin_count, m_last_bin);
                end else begin
                    exp_bin = expected_bins.pop_front();
                    if (m_bin_index !== exp_bin.idx || m_bin_count !== exp_bin.cnt ||
                        m_last_bin !== exp_bin.last) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("ERROR: expected idx=%0d count=%0d last=%0b, %s%0d %0d %0b",
                                     exp_bin.idx, exp_bin.cnt, exp_bin.last,
                                     "got ", m_bin_index, m_bin_count, m_last_bin);
                    end
                end
            end
            m_ready <= stall_pat[stall_ph];
            stall_ph = (stall_ph + 1) % 32;
            if (stall_ph == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n_rand;
        int unsigned seg_len;
        int unsigned run_cat;
        int unsigned flood_at;
        bit          flooded;

        // Reads straight after reset see the whole window in category 0.
        push_word(REQ_READ, 0);
        push_word(REQ_READ, 0);
        push_word(REQ_SAMPLE, 15);
        push_word(REQ_SAMPLE, 0);
        push_word(REQ_SAMPLE, 5);
        push_word(REQ_SAMPLE, 10);
        push_word(REQ_READ, 0);
        push_word(REQ_SAMPLE, 15);
        push_word(REQ_SAMPLE, 15);
        push_word(REQ_SAMPLE, 15);
        // The category field is ignored on a read.
        push_word(REQ_READ, 15);
        push_word(REQ_SAMPLE, 1);
        push_word(REQ_SAMPLE, 2);
        push_word(REQ_SAMPLE, 4);
        push_word(REQ_SAMPLE, 8);
        push_word(REQ_READ, 10);
        push_word(REQ_READ, 5);

        // One flood fills the whole window with a single category and wraps
        // the write position; the rest mixes scattered samples, runs and reads.
        n_rand   = 0;
        flooded  = 0;
        flood_at = $urandom_range(0, 150);
        while (n_rand < RAND_WORDS) begin
            if (!flooded && n_rand >= flood_at) begin
                flooded = 1;
                run_cat = $urandom_range(1, NCAT - 1);
                seg_len = $urandom_range(DEPTH, DEPTH + 40);
                repeat (seg_len) push_word(REQ_SAMPLE, run_cat);
                push_word(REQ_READ, $urandom_range(0, NCAT - 1));
                n_rand += seg_len + 1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        seg_len = $urandom_range(1, 20);
                        repeat (seg_len) push_word(REQ_SAMPLE, $urandom_range(0, NCAT - 1));
                        n_rand += seg_len;
                    end
                    5, 6: begin
                        seg_len = $urandom_range(1, 48);
                        run_cat = $urandom_range(0, NCAT - 1);
                        repeat (seg_len) push_word(REQ_SAMPLE, run_cat);
                        n_rand += seg_len;
                    end
                    default: begin
                        push_word(REQ_READ, $urandom_range(0, NCAT - 1));
                        n_rand++;
                    end
                endcase
            end
        end
        push_word(REQ_READ, 0);
        words_total = pending_words.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (words_accepted == words_total && expected_bins.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
